// ===== rtl/tpdt_pkg.sv =====
// Package for the triangle pixel depth test block.
// Holds widths and register indexes; depends on nothing.
package tpdt_pkg;
    localparam int CoordW      = 12;
    localparam int PixW        = 9;
    localparam int DepthW      = 24;
    localparam int ColorW      = 24;
    localparam int CfgIdxW     = 3;
    localparam int EdgeW       = 26;
    localparam int NumW        = 52;
    localparam int DefWidth    = 512;
    localparam int DefHeight   = 512;

    localparam logic [CfgIdxW-1:0] REG_VERTEX_A = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_VERTEX_B = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_VERTEX_C = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_DEPTH_A  = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_DEPTH_B  = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_DEPTH_C  = 3'd5;
    localparam logic [CfgIdxW-1:0] REG_COLOR    = 3'd6;

    localparam logic signed [DepthW-1:0] DEPTH_MIN = {1'b1, {(DepthW-1){1'b0}}};
endpackage

// ===== rtl/tpdt_divider.sv =====
// Pipelined signed divider, truncating toward zero, one quotient bit a stage.
// Uses tpdt_pkg for its widths; carries a tag through with the quotient.
module tpdt_divider
    import tpdt_pkg::*;
#(
    parameter int TagW = 20
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [TagW-1:0]             in_tag,
    input  logic signed [NumW-1:0]      in_num,
    input  logic signed [EdgeW-1:0]     in_den,
    output logic                        out_valid,
    output logic [TagW-1:0]             out_tag,
    output logic signed [DepthW-1:0]    out_quot
);
    localparam int QW = DepthW + 1;
    localparam int Stages = QW;

    logic                  v_reg   [Stages+1];
    logic [TagW-1:0]       t_reg   [Stages+1];
    logic [NumW-1:0]       r_reg   [Stages+1];
    logic [EdgeW-1:0]      d_reg   [Stages+1];
    logic [QW-1:0]         q_reg   [Stages+1];
    logic                  n_reg   [Stages+1];

    logic [NumW-1:0]  num_abs;
    logic [EdgeW-1:0] den_abs;

    assign num_abs = in_num[NumW-1] ? NumW'(-in_num) : NumW'(in_num);
    assign den_abs = in_den[EdgeW-1] ? EdgeW'(-in_den) : EdgeW'(in_den);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= Stages; i++)
                v_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
            for (int i = 1; i <= Stages; i++)
                v_reg[i] <= v_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg[0] <= in_tag;
            r_reg[0] <= num_abs;
            d_reg[0] <= den_abs;
            q_reg[0] <= '0;
            n_reg[0] <= in_num[NumW-1] ^ in_den[EdgeW-1];
            for (int i = 1; i <= Stages; i++)
            begin
                t_reg[i] <= t_reg[i-1];
                d_reg[i] <= d_reg[i-1];
                n_reg[i] <= n_reg[i-1];
                if ((NumW+EdgeW)'(r_reg[i-1]) >=
                    ((NumW+EdgeW)'(d_reg[i-1]) << (QW-i)))
                begin
                    r_reg[i] <= NumW'((NumW+EdgeW)'(r_reg[i-1]) -
                                ((NumW+EdgeW)'(d_reg[i-1]) << (QW-i)));
                    q_reg[i] <= q_reg[i-1] | (QW'(1) << (QW-i));
                end
                else
                begin
                    r_reg[i] <= r_reg[i-1];
                    q_reg[i] <= q_reg[i-1];
                end
            end
        end
    end

    assign out_valid = v_reg[Stages];
    assign out_tag   = t_reg[Stages];
    assign out_quot  = n_reg[Stages] ? DepthW'(-q_reg[Stages]) : DepthW'(q_reg[Stages]);
endmodule

// ===== rtl/triangle_pixel_depth_test.sv =====
// Triangle pixel coverage and depth test top level, one pixel per cycle when not stalled.
// Pipeline order: edges, weighted sum, divider, depth store read, output register.
// Throughput, set by the depth store RAM port pair: one word per cycle when not stalled.
// Reset: registers clear, then a clearing pass writes the most negative depth to every
// depth store word (SCREEN_WIDTH*SCREEN_HEIGHT at power-of-two sizes); no input then.
// Uses tpdt_pkg and tpdt_divider.
module triangle_pixel_depth_test
    import tpdt_pkg::*;
#(
    parameter int SCREEN_WIDTH  = DefWidth,
    parameter int SCREEN_HEIGHT = DefHeight
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_write_enable,
    input  logic [CfgIdxW-1:0]         cfg_index,
    input  logic [DepthW-1:0]          cfg_data,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [PixW-1:0]            pixel_x,
    input  logic [PixW-1:0]            pixel_y,
    input  logic                       mode,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic                       write_enable,
    output logic [PixW-1:0]            write_x,
    output logic [PixW-1:0]            write_y,
    output logic [ColorW-1:0]          write_color,
    output logic signed [DepthW-1:0]   pixel_depth
);
    localparam int XW = $clog2(SCREEN_WIDTH);
    localparam int YW = $clog2(SCREEN_HEIGHT);
    localparam int AW = XW + YW;
    localparam int Depth = 1 << AW;
    localparam int TagW = 2 + 2 * PixW;
    localparam int PW = 2 * CoordW + 2;

    logic [2*CoordW-1:0]        vert_reg [3];
    logic signed [DepthW-1:0]   dep_reg  [3];
    logic [ColorW-1:0]          color_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                vert_reg[i] <= '0;
                dep_reg[i]  <= '0;
            end
            color_reg <= '0;
        end
        else if (cfg_write_enable)
        begin
            case (cfg_index)
                REG_VERTEX_A: vert_reg[0] <= cfg_data;
                REG_VERTEX_B: vert_reg[1] <= cfg_data;
                REG_VERTEX_C: vert_reg[2] <= cfg_data;
                REG_DEPTH_A:  dep_reg[0]  <= cfg_data;
                REG_DEPTH_B:  dep_reg[1]  <= cfg_data;
                REG_DEPTH_C:  dep_reg[2]  <= cfg_data;
                REG_COLOR:    color_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // clearing pass
    logic          clr_busy_reg;
    logic [AW:0]   clr_cnt_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end
        else if (clr_busy_reg)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == (AW+1)'(Depth - 1))
                clr_busy_reg <= 1'b0;
        end
    end

    // pipeline enable: the whole pipe holds when the output word is stalled
    logic en;
    logic out_valid_reg;
    assign en = !(out_valid_reg && out_stall);
    assign in_stall = !en || clr_busy_reg;
    wire accept = in_valid && !in_stall;

    // stage 1: differences
    logic signed [CoordW-1:0] ax, ay, bx, by, cx, cy;
    assign ax = vert_reg[0][CoordW-1:0];
    assign ay = vert_reg[0][2*CoordW-1:CoordW];
    assign bx = vert_reg[1][CoordW-1:0];
    assign by = vert_reg[1][2*CoordW-1:CoordW];
    assign cx = vert_reg[2][CoordW-1:0];
    assign cy = vert_reg[2][2*CoordW-1:CoordW];

    logic                       s1_v_reg, s2_v_reg, s3_v_reg;
    logic [PixW-1:0]            s1_x_reg, s1_y_reg, s2_x_reg, s2_y_reg;
    logic                       s1_m_reg, s2_m_reg;
    logic signed [CoordW+1:0]   d_cxax_reg, d_ayp_reg, d_axp_reg, d_cyay_reg;
    logic signed [CoordW+1:0]   d_byay_reg, d_bxax_reg;
    logic signed [PW-1:0]       p0_reg, p1_reg, p2_reg, p3_reg, p4_reg, p5_reg;
    logic signed [EdgeW-1:0]    e0_reg, e1_reg, area_reg;
    logic                       s3_in_reg, s3_m_reg;
    logic [PixW-1:0]            s3_x_reg, s3_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_v_reg <= accept;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
        end
    end

    logic signed [EdgeW-1:0] e0_n, e1_n, area_n;
    logic signed [EdgeW:0]   sum_n;
    logic                    in_n, on_screen;
    assign e0_n   = EdgeW'(p0_reg - p1_reg);
    assign e1_n   = EdgeW'(p2_reg - p3_reg);
    assign area_n = EdgeW'(p4_reg - p5_reg);
    assign sum_n  = (EdgeW+1)'(e0_n) + (EdgeW+1)'(e1_n);
    assign on_screen = (int'(s2_x_reg) < SCREEN_WIDTH)
                    && (int'(s2_y_reg) < SCREEN_HEIGHT);
    always_comb
    begin
        if (area_n > 0)
            in_n = e0_n >= 0 && e1_n >= 0 && sum_n <= area_n;
        else if (area_n < 0)
            in_n = e0_n <= 0 && e1_n <= 0 && sum_n >= area_n;
        else
            in_n = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_x_reg   <= pixel_x;
            s1_y_reg   <= pixel_y;
            s1_m_reg   <= mode;
            d_cxax_reg <= (CoordW+2)'(cx) - (CoordW+2)'(ax);
            d_ayp_reg  <= (CoordW+2)'(ay) - (CoordW+2)'(signed'({1'b0, pixel_y}));
            d_axp_reg  <= (CoordW+2)'(ax) - (CoordW+2)'(signed'({1'b0, pixel_x}));
            d_cyay_reg <= (CoordW+2)'(cy) - (CoordW+2)'(ay);
            d_byay_reg <= (CoordW+2)'(by) - (CoordW+2)'(ay);
            d_bxax_reg <= (CoordW+2)'(bx) - (CoordW+2)'(ax);

            s2_x_reg <= s1_x_reg;
            s2_y_reg <= s1_y_reg;
            s2_m_reg <= s1_m_reg;
            p0_reg <= PW'(d_cxax_reg * d_ayp_reg);
            p1_reg <= PW'(d_axp_reg * d_cyay_reg);
            p2_reg <= PW'(d_axp_reg * d_byay_reg);
            p3_reg <= PW'(d_bxax_reg * d_ayp_reg);
            p4_reg <= PW'(d_bxax_reg * d_cyay_reg);
            p5_reg <= PW'(d_cxax_reg * d_byay_reg);

            s3_x_reg  <= s2_x_reg;
            s3_y_reg  <= s2_y_reg;
            s3_m_reg  <= s2_m_reg;
            s3_in_reg <= in_n && on_screen;
            e0_reg    <= e0_n;
            e1_reg    <= e1_n;
            area_reg  <= area_n;
        end
    end

    // stage 4: weighted sum products, stage 5: sum
    logic                       s4_v_reg, s5_v_reg;
    logic [TagW-1:0]            s4_t_reg, s5_t_reg;
    logic signed [NumW-1:0]     q0_reg, q1_reg, q2_reg, num_reg;
    logic signed [EdgeW-1:0]    s4_a_reg, s5_a_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_v_reg <= 1'b0;
            s5_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s4_v_reg <= s3_v_reg;
            s5_v_reg <= s4_v_reg;
        end
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_t_reg <= {s3_in_reg, s3_m_reg, s3_x_reg, s3_y_reg};
            s4_a_reg <= s3_in_reg ? area_reg : EdgeW'(1);
            q0_reg <= NumW'(dep_reg[0] * (area_reg - e0_reg - e1_reg));
            q1_reg <= NumW'(dep_reg[1] * e0_reg);
            q2_reg <= NumW'(dep_reg[2] * e1_reg);
            s5_t_reg <= s4_t_reg;
            s5_a_reg <= s4_a_reg;
            num_reg  <= q0_reg + q1_reg + q2_reg;
        end
    end

    logic                      dv_v;
    logic [TagW-1:0]           dv_t;
    logic signed [DepthW-1:0]  dv_q;
    tpdt_divider #(.TagW(TagW)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s5_v_reg),
        .in_tag    (s5_t_reg),
        .in_num    (num_reg),
        .in_den    (s5_a_reg),
        .out_valid (dv_v),
        .out_tag   (dv_t),
        .out_quot  (dv_q)
    );

    // depth store read stage with forwarding
    logic [DepthW-1:0]   mem [Depth];
    logic [DepthW-1:0]   rd_reg;
    logic                r_v_reg, r_in_reg, r_m_reg;
    logic [PixW-1:0]     r_x_reg, r_y_reg;
    logic signed [DepthW-1:0] r_d_reg;
    logic [AW-1:0]       r_a_reg;
    logic [AW-1:0]       rd_addr;
    logic                upd;
    logic [AW-1:0]       wr_addr;
    logic [DepthW-1:0]   wr_data;
    logic                fwd_reg;
    logic [DepthW-1:0]   fwd_d_reg;
    logic signed [DepthW-1:0] stored;

    assign rd_addr = {YW'(dv_t[PixW-1:0]), XW'(dv_t[2*PixW-1:PixW])};
    assign stored  = fwd_reg ? fwd_d_reg : rd_reg;
    assign upd = en && r_v_reg && r_in_reg && r_m_reg && (stored < r_d_reg);
    assign wr_addr = clr_busy_reg ? clr_cnt_reg[AW-1:0] : r_a_reg;
    assign wr_data = clr_busy_reg ? DEPTH_MIN : r_d_reg;

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg || upd)
            mem[wr_addr] <= wr_data;
        if (en)
            rd_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            r_v_reg <= 1'b0;
        else if (en)
            r_v_reg <= dv_v;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_in_reg  <= dv_t[TagW-1];
            r_m_reg   <= dv_t[TagW-2];
            r_x_reg   <= dv_t[2*PixW-1:PixW];
            r_y_reg   <= dv_t[PixW-1:0];
            r_d_reg   <= dv_q;
            r_a_reg   <= rd_addr;
            fwd_reg   <= upd && (r_a_reg == rd_addr);
            fwd_d_reg <= r_d_reg;
        end
    end

    // output register
    logic               we_reg;
    logic [PixW-1:0]    ox_reg, oy_reg;
    logic [ColorW-1:0]  oc_reg;
    logic [DepthW-1:0]  od_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= r_v_reg;
    end
    logic we_n;
    assign we_n = r_in_reg && (!r_m_reg || (stored < r_d_reg));
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            we_reg <= we_n;
            ox_reg <= r_x_reg;
            oy_reg <= r_y_reg;
            oc_reg <= we_n ? color_reg : '0;
            od_reg <= (r_in_reg && r_m_reg) ? r_d_reg : '0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign write_enable = we_reg;
    assign write_x      = ox_reg;
    assign write_y      = oy_reg;
    assign write_color  = oc_reg;
    assign pixel_depth  = od_reg;

`ifndef SYNTHESIS
    a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy_reg |-> !accept) else $error("word accepted during clear");
    a_fwd_update: assert property (@(posedge clk) disable iff (!rst_n)
        (upd && clr_busy_reg) |-> 1'b0) else $error("update during clear");
    a_color_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !write_enable) |-> (write_color == '0))
        else $error("color without write");
`endif
endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for triangle_pixel_depth_test: drives pixel words,
// predicts coverage, depth and store updates, and checks each output word.
// Depends on tpdt_pkg and the triangle_pixel_depth_test RTL.
`timescale 1ns / 100ps

module testbench;
    import tpdt_pkg::*;

    localparam int ScreenW = 512;
    localparam int ScreenH = 512;
    localparam int LatencyCycles = 40;
    localparam int HoldCycles = 200;
    localparam longint CycleLimit = 3_000_000;

    typedef struct packed {
        logic              we;
        logic [PixW-1:0]   x;
        logic [PixW-1:0]   y;
        logic [ColorW-1:0] color;
        logic [DepthW-1:0] depth;
    } pixel_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write_enable = 1'b0;
    logic [CfgIdxW-1:0] cfg_index = '0;
    logic [DepthW-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [PixW-1:0] pixel_x = '0;
    logic [PixW-1:0] pixel_y = '0;
    logic mode = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic write_enable;
    logic [PixW-1:0] write_x;
    logic [PixW-1:0] write_y;
    logic [ColorW-1:0] write_color;
    logic signed [DepthW-1:0] pixel_depth;

    logic [23:0] vert_reg [3];
    logic signed [23:0] depth_reg [3];
    logic [23:0] color_reg;
    logic signed [23:0] zbuf [ScreenW*ScreenH];

    pixel_result_t expected_pixels [$];
    int mismatches = 0;
    longint cycles = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_cycles = 0;
    int hold_req = 0;
    int hold_seen = 0;

    triangle_pixel_depth_test uut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic longint sx12(logic [11:0] v);
        return longint'($signed(v));
    endfunction

    function automatic pixel_result_t predict_pixel(logic [PixW-1:0] px_u,
                                                    logic [PixW-1:0] py_u, logic m);
        pixel_result_t r;
        longint ax, ay, bx, by, cx, cy, px, py, e0, e1, area, sum, num, d;
        bit hit;
        int idx;
        ax = sx12(vert_reg[0][11:0]); ay = sx12(vert_reg[0][23:12]);
        bx = sx12(vert_reg[1][11:0]); by = sx12(vert_reg[1][23:12]);
        cx = sx12(vert_reg[2][11:0]); cy = sx12(vert_reg[2][23:12]);
        px = px_u; py = py_u;
        e0 = (cx-ax)*(ay-py) - (ax-px)*(cy-ay);
        e1 = (ax-px)*(by-ay) - (bx-ax)*(ay-py);
        area = (bx-ax)*(cy-ay) - (cx-ax)*(by-ay);
        sum = e0 + e1;
        if (area > 0) hit = e0 >= 0 && e1 >= 0 && sum <= area;
        else if (area < 0) hit = e0 <= 0 && e1 <= 0 && sum >= area;
        else hit = 0;
        if (px >= ScreenW || py >= ScreenH) hit = 0;
        r = '0;
        r.x = px_u;
        r.y = py_u;
        d = 0;
        if (hit)
        begin
            if (!m) r.we = 1'b1;
            else
            begin
                idx = int'(py*ScreenW + px);
                num = longint'(depth_reg[0])*(area-sum) + longint'(depth_reg[1])*e0
                    + longint'(depth_reg[2])*e1;
                d = num / area;
                if (longint'(zbuf[idx]) < d)
                begin
                    zbuf[idx] = d[23:0];
                    r.we = 1'b1;
                end
            end
        end
        if (r.we) r.color = color_reg;
        r.depth = d[23:0];
        return r;
    endfunction

    task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [23:0] val);
        @(negedge clk);
        cfg_write_enable <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_write_enable <= 1'b0;
        if (idx < REG_DEPTH_A) vert_reg[idx] = val;
        else if (idx < REG_COLOR) depth_reg[idx - REG_DEPTH_A] = val;
        else color_reg = val;
    endtask

    task automatic set_triangle(logic [23:0] a, logic [23:0] b, logic [23:0] c,
                                logic [23:0] da, logic [23:0] db, logic [23:0] dc,
                                logic [23:0] col);
        write_reg(REG_VERTEX_A, a);
        write_reg(REG_VERTEX_B, b);
        write_reg(REG_VERTEX_C, c);
        write_reg(REG_DEPTH_A, da);
        write_reg(REG_DEPTH_B, db);
        write_reg(REG_DEPTH_C, dc);
        write_reg(REG_COLOR, col);
    endtask

    function automatic logic [23:0] vert(int x, int y);
        logic [11:0] xs, ys;
        xs = x[11:0];
        ys = y[11:0];
        return {ys, xs};
    endfunction

    // Send one pixel word at a falling edge; predict at acceptance.
    task automatic send_pixel(logic [PixW-1:0] x, logic [PixW-1:0] y, logic m);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        pixel_x <= x;
        pixel_y <= y;
        mode <= m;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_pixels.push_back(predict_pixel(x, y, m));
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (LatencyCycles) @(posedge clk);
        @(negedge clk);
    endtask

    always @(negedge clk)
    begin
        if (hold_req != hold_seen)
        begin
            hold_seen <= hold_req;
            hold_cycles <= HoldCycles;
            out_stall <= 1'b1;
        end
        else if (hold_cycles > 0)
        begin
            out_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            pixel_result_t exp_r;
            if (expected_pixels.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: x=%0d y=%0d", write_x, write_y);
            end
            else
            begin
                exp_r = expected_pixels.pop_front();
                if (exp_r.we !== write_enable || exp_r.x !== write_x ||
                    exp_r.y !== write_y || exp_r.color !== write_color ||
                    exp_r.depth !== pixel_depth)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp we=%0d x=%0d y=%0d c=%h z=%h, got we=%0d x=%0d y=%0d c=%h z=%h",
                            exp_r.we, exp_r.x, exp_r.y, exp_r.color, exp_r.depth,
                            write_enable, write_x, write_y, write_color, pixel_depth);
                end
            end
        end
    end

    task automatic test_directed();
        set_triangle(vert(0, 0), vert(511, 0), vert(0, 511), 24'h7FFFFF, 24'h800000,
                     24'h000100, 24'hFFFFFF);
        send_pixel(0, 0, 0);
        send_pixel(511, 511, 0);
        send_pixel(255, 255, 0);
        send_pixel(0, 0, 1);
        send_pixel(0, 0, 1);
        send_pixel(511, 0, 1);
        send_pixel(0, 511, 1);
        send_pixel(100, 100, 1);
        send_pixel(300, 300, 1);
        drain();
        set_triangle(vert(-2048, -2048), vert(2047, -2048), vert(-2048, 2047),
                     24'h800000, 24'h800000, 24'h800000, 24'h000000);
        send_pixel(10, 10, 1);
        send_pixel(511, 511, 1);
        send_pixel(20, 20, 0);
        drain();
        set_triangle(vert(10, 10), vert(20, 20), vert(30, 30), 24'h0, 24'h0, 24'h0,
                     24'h123456);
        send_pixel(20, 20, 0);
        send_pixel(20, 20, 1);
        drain();
        set_triangle(vert(0, 0), vert(0, 100), vert(100, 0), 24'h001000, 24'h002000,
                     24'h003000, 24'hA5A5A5);
        send_pixel(50, 50, 0);
        send_pixel(0, 0, 1);
        send_pixel(50, 50, 1);
        send_pixel(50, 50, 1);
        send_pixel(60, 60, 1);
        drain();
    endtask

    task automatic test_random(int n, int idle, int stall);
        int cx, cy, r;
        send_idle_pct = idle;
        stall_pct = stall;
        for (int i = 0; i < n; i++)
        begin
            if (i % 40 == 0)
            begin
                drain();
                cx = $urandom_range(511);
                cy = $urandom_range(511);
                r = $urandom_range(1, 64);
                set_triangle(vert(cx - int'($urandom_range(r)), cy - int'($urandom_range(r))),
                    vert(cx + int'($urandom_range(r)), cy - int'($urandom_range(r))),
                    vert(cx - r + int'($urandom_range(2*r)), cy + int'($urandom_range(r))),
                    24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom));
                if ($urandom_range(9) == 0)
                    write_reg(REG_VERTEX_C, 24'($urandom));
            end
            if ($urandom_range(9) < 8)
                send_pixel(PixW'(cx - r + int'($urandom_range(2*r))),
                           PixW'(cy - r + int'($urandom_range(2*r))),
                           $urandom_range(3) != 0);
            else
                send_pixel(PixW'($urandom), PixW'($urandom), 1'($urandom));
        end
        drain();
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        stall_pct = 0;
        hold_req++;
        for (int i = 0; i < 80; i++)
            send_pixel(PixW'($urandom_range(40)), PixW'($urandom_range(40)), 1'($urandom));
        drain();
    endtask

    initial
    begin
        for (int i = 0; i < 3; i++)
        begin
            vert_reg[i] = '0;
            depth_reg[i] = '0;
        end
        color_reg = '0;
        for (int i = 0; i < ScreenW*ScreenH; i++)
            zbuf[i] = DEPTH_MIN;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_random(260, 0, 0);
        test_random(260, 47, 0);
        test_random(260, 0, 47);
        test_random(260, 15, 15);
        test_backpressure();
        drain();
        if (mismatches == 0 && expected_pixels.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

// ===== triangle_pixel_depth_test.f =====
rtl/tpdt_pkg.sv
rtl/tpdt_divider.sv
rtl/triangle_pixel_depth_test.sv
tb/testbench.sv
